FILE: design/linear_svm_sgd_trainer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear SVM SGD trainer
// Shared property forms with clock and reset built in.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SVM_SGD_TRAINER_TOP_ASSERT_SVH
`define LINEAR_SVM_SGD_TRAINER_TOP_ASSERT_SVH

// same-cycle implication
`define LSVM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lsvm_pkg.sv
// ----------------------------------------------------------------------------
// lsvm_pkg
// Types, constants and helpers shared by the linear SVM SGD trainer.
// ----------------------------------------------------------------------------
package lsvm_pkg;

	// sizes
	localparam int NUM_FEATURES_DEF = 8;
	localparam int FEAT_W  = 16;
	localparam int WGT_W   = 32;
	localparam int RATE_W  = 16;
	localparam int PROD_W  = WGT_W + FEAT_W;
	localparam int KEEP_W  = 35;
	localparam int OUT_W   = 40;
	localparam int ACT_W   = 2;

	// action codes; code 3 behaves as predict
	localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TRAIN   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

	// register indexes
	localparam logic CFG_LEARN_RATE   = 1'b0;
	localparam logic CFG_REG_STRENGTH = 1'b1;

	localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

	// margin bounds in Q8.24
	localparam logic signed [WGT_W-1:0] ONE_Q24     = 32'sh0100_0000;
	localparam logic signed [WGT_W-1:0] NEG_ONE_Q24 = 32'shFF00_0000;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_COMMIT
	} lsvm_state_t;

	// update command from the control to every lane
	typedef struct packed {
		logic wr;       // apply decay (and step)
		logic clr;      // zero the weight
		logic step_en;  // margin violated: add the hinge step
		logic pos;      // label is +1
	} lsvm_upd_t;

	// saturate a 35-bit signed value to 32 bits
	function automatic logic signed [WGT_W-1:0] lsvm_sat35(input logic signed [KEEP_W-1:0] v);
		logic ovf;
		ovf = !((&v[KEEP_W-1:WGT_W-1]) || !(|v[KEEP_W-1:WGT_W-1]));
		if (ovf) begin
			return v[KEEP_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[WGT_W-1:0];
	endfunction

endpackage

FILE: design/lsvm_lane.sv
// ----------------------------------------------------------------------------
// lsvm_lane
// One feature lane: holds a weight, forms its product term for the score and
// prepares the decayed weight and hinge step for the commit.
// ----------------------------------------------------------------------------
module lsvm_lane
	import lsvm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [FEAT_W-1:0] x,
	input  logic [RATE_W-1:0]        lr,
	input  logic [2*RATE_W-1:0]      lrlam,
	input  lsvm_upd_t                upd,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [WGT_W-1:0]  weight_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [64:0]       decay_s1;
	logic signed [32:0]       step_s1;
	logic signed [64:0]       decay_rnd;
	logic signed [32:0]       step_rnd;
	logic signed [KEEP_W-1:0] keep_s2;
	logic signed [28:0]       step_s2;
	logic signed [KEEP_W-1:0] new_w;

	// stage 1: multiplies
	always_ff @(posedge clk) begin
		prod_s1  <= weight_q * x;
		decay_s1 <= $signed({1'b0, lrlam}) * weight_q;
		step_s1  <= $signed({1'b0, lr}) * x;
	end

	// stage 2: round half up, then decayed weight
	assign decay_rnd = decay_s1 + 65'sh0_8000_0000;
	assign step_rnd  = step_s1 + 33'sd8;

	always_ff @(posedge clk) begin
		keep_s2 <= KEEP_W'(weight_q) - KEEP_W'($signed(decay_rnd[64:32]));
		step_s2 <= step_rnd[32:4];
	end

	// commit value
	always_comb begin
		new_w = keep_s2;
		if (upd.step_en) begin
			new_w = upd.pos ? keep_s2 + KEEP_W'(step_s2) : keep_s2 - KEEP_W'(step_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (upd.clr) begin
			weight_q <= '0;
		end else if (upd.wr) begin
			weight_q <= lsvm_sat35(new_w);
		end
	end

	assign prod = prod_s1;

endmodule

FILE: design/lsvm_merge.sv
// ----------------------------------------------------------------------------
// lsvm_merge
// Registered adder tree over the lane products, then scale, bias add and
// saturation to the Q8.24 decision score.
// ----------------------------------------------------------------------------
module lsvm_merge
	import lsvm_pkg::*;
#(
	parameter int NUM_FEATURES = NUM_FEATURES_DEF
) (
	input  logic                     clk,
	input  logic signed [PROD_W-1:0] prod [NUM_FEATURES],
	input  logic signed [WGT_W-1:0]  bias,
	output logic signed [WGT_W-1:0]  score
);

	localparam int LVL   = $clog2(NUM_FEATURES);
	localparam int P     = 1 << LVL;
	localparam int ACC_W = PROD_W + LVL;
	localparam int SW    = ACC_W - 11;

	logic signed [ACC_W-1:0]  leaf_c [P];
	logic signed [ACC_W-1:0]  node_q [1:2*P-1];
	logic signed [ACC_W-13:0] shr_c;
	logic signed [SW-1:0]     sum_c;
	logic                     ovf_c;
	logic signed [WGT_W-1:0]  score_q;

	// leaves, padded with zeros up to a power of two
	for (genvar g = 0; g < P; g++) begin : g_leaf
		if (g < NUM_FEATURES) begin : g_used
			assign leaf_c[g] = ACC_W'(prod[g]);
		end else begin : g_pad
			assign leaf_c[g] = '0;
		end
	end

	// one tree level per cycle; node k sums nodes 2k and 2k+1
	always_ff @(posedge clk) begin
		for (int i = 0; i < P; i++) begin
			node_q[P+i] <= leaf_c[i];
		end
		for (int k = 1; k < P; k++) begin
			node_q[k] <= node_q[2*k] + node_q[2*k+1];
		end
	end

	// floor shift by 12, bias add, saturate
	assign shr_c = node_q[1][ACC_W-1:12];
	assign sum_c = SW'(shr_c) + SW'(bias);
	assign ovf_c = !((&sum_c[SW-1:WGT_W-1]) || !(|sum_c[SW-1:WGT_W-1]));

	always_ff @(posedge clk) begin
		if (ovf_c) begin
			score_q <= sum_c[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			score_q <= sum_c[WGT_W-1:0];
		end
	end

	assign score = score_q;

endmodule

FILE: design/linear_svm_sgd_trainer_top.sv
// ----------------------------------------------------------------------------
// linear_svm_sgd_trainer_top
// Linear SVM with one hinge-loss SGD step per training item, one lane per feature.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per sample; s_tuser carries the action (predict,
// train, clear), s_tdata the label and the Q4.12 features. Output channel m_*
// returns one item per input item: class, Q8.24 score and margin flag.
// cfg_*: write learn_rate (index 0) and reg_strength (index 1), Q0.16.
// An item runs through the input register, the lane multiply, the registered
// adder tree (one level per cycle) and the score stage before it commits and
// m_tvalid rises. One item is in flight at a time and the next is taken on
// the cycle its predecessor commits, since all of these stages must finish
// before the weights are rewritten.
// Reset clears weights and bias and loads both rates with 655.
// A finished result waits in the output register; while m_tready is low the
// next item still runs up to its commit and then holds there until the
// output register frees.
// ----------------------------------------------------------------------------
`include "linear_svm_sgd_trainer_top_assert.svh"

module linear_svm_sgd_trainer_top
	import lsvm_pkg::*;
#(
	parameter int NUM_FEATURES = NUM_FEATURES_DEF,
	localparam int IN_W = ((1 + FEAT_W * NUM_FEATURES + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // sample_label, feature_0 .. feature_N-1
	input  logic [ACT_W-1:0]  s_tuser,   // action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // predicted_class, decision_score, margin_violated
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [RATE_W-1:0] cfg_data
);

	localparam int LVL       = $clog2(NUM_FEATURES);
	localparam int CALC_LAST = LVL + 2;
	localparam int CNT_W     = $clog2(CALC_LAST + 2);

	lsvm_state_t              state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [RATE_W-1:0]        lr_q;
	logic [RATE_W-1:0]        lam_q;
	logic [2*RATE_W-1:0]      lrlam_q;
	logic signed [FEAT_W-1:0] x_q [NUM_FEATURES];
	logic                     label_q;
	logic [ACT_W-1:0]         action_q;
	logic signed [WGT_W-1:0]  bias_q;
	logic signed [PROD_W-1:0] prod [NUM_FEATURES];
	logic signed [WGT_W-1:0]  score;
	logic                     viol;
	logic                     accept;
	logic                     out_free;
	logic                     commit_fire;
	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_tdata_q;
	lsvm_upd_t                upd;
	logic signed [KEEP_W-1:0] bias_new;

	// configuration registers and the lr*lambda product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= RATE_RESET;
			lam_q <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEARN_RATE:   lr_q  <= cfg_data;
				CFG_REG_STRENGTH: lam_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lrlam_q <= lr_q * lam_q;
	end

	// handshake
	assign out_free    = !m_tvalid_q || m_tready;
	assign accept      = s_tvalid && s_tready;

	// control outputs
	always_comb begin
		s_tready    = 1'b0;
		commit_fire = 1'b0;
		unique case (state_q)
			S_IDLE:   s_tready = 1'b1;
			S_CALC:   s_tready = 1'b0;
			S_COMMIT: begin
				s_tready    = out_free;
				commit_fire = out_free;
			end
			default:  s_tready = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = S_CALC;
			S_CALC:   if (cnt_q == CNT_W'(CALC_LAST)) state_d = S_COMMIT;
			S_COMMIT: if (commit_fire) state_d = accept ? S_CALC : S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == S_CALC) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			label_q  <= s_tdata[0];
			action_q <= s_tuser;
			for (int i = 0; i < NUM_FEATURES; i++) begin
				x_q[i] <= s_tdata[1 + FEAT_W*i +: FEAT_W];
			end
		end
	end

	// lanes
	for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
		lsvm_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.x      (x_q[g]),
			.lr     (lr_q),
			.lrlam  (lrlam_q),
			.upd    (upd),
			.prod   (prod[g])
		);
	end

	lsvm_merge #(
		.NUM_FEATURES (NUM_FEATURES)
	) u_merge (
		.clk   (clk),
		.prod  (prod),
		.bias  (bias_q),
		.score (score)
	);

	// margin test on the saturated score
	assign viol = label_q ? (score < ONE_Q24) : (score > NEG_ONE_Q24);

	assign upd.wr      = commit_fire && (action_q == ACT_TRAIN);
	assign upd.clr     = commit_fire && (action_q == ACT_CLEAR);
	assign upd.step_en = viol;
	assign upd.pos     = label_q;

	// bias update
	assign bias_new = label_q ? KEEP_W'(bias_q) + KEEP_W'($signed({1'b0, lr_q, 8'h00}))
	                          : KEEP_W'(bias_q) - KEEP_W'($signed({1'b0, lr_q, 8'h00}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (upd.clr) begin
			bias_q <= '0;
		end else if (upd.wr && viol) begin
			bias_q <= lsvm_sat35(bias_new);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_fire) begin
			if (action_q == ACT_CLEAR) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {6'b0, viol, score, ~score[WGT_W-1]};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// checks
	`LSVM_ASSERT_IMPLY(a_accept_state, accept, (state_q == S_IDLE) || (state_q == S_COMMIT), "item accepted while busy")
	`LSVM_ASSERT_NEXT(a_commit_out, commit_fire, m_tvalid, "commit without result")
	`LSVM_ASSERT_NEXT(a_clear_zero, commit_fire && (action_q == ACT_CLEAR), (bias_q == '0) && (m_tdata == '0), "clear left state or result nonzero")
	`LSVM_ASSERT_NEXT(a_bias_hold, !commit_fire, $stable(bias_q), "bias changed outside commit")

endmodule

FILE: tb/sv/linear_svm_sgd_trainer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_svm_sgd_trainer_top_tb
// Self-checking bench for the hinge-loss SGD trainer. A cycle-free model of
// the weights and bias predicts class, score and margin flag for every
// accepted item. Directed items cover saturation, clear, the unused action
// code, decay and both rate extremes. Random traffic follows under several
// rate settings and source/sink idling mixes, with one long output stall.
// ----------------------------------------------------------------------------
module linear_svm_sgd_trainer_top_tb;
	import lsvm_pkg::*;

	localparam int NF        = NUM_FEATURES_DEF;
	localparam int TB_IN_W   = ((1 + FEAT_W * NF + 7) / 8) * 8;
	localparam int PIPE_LAT  = $clog2(NF) + 4;
	localparam int CYCLE_CAP = 400000;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // decoded as predict

	localparam longint S32_HI  = longint'(32'sh7FFF_FFFF);
	localparam longint S32_LO  = longint'(32'sh8000_0000);
	localparam longint Q24_ONE = longint'(ONE_Q24);
	localparam longint HALF_32 = longint'(1) << 31;

	typedef struct packed {
		logic [ACT_W-1:0]             act;
		logic                         label;
		logic [NF-1:0][FEAT_W-1:0]    feat;
	} sample_t;

	typedef struct packed {
		logic              viol;
		logic [WGT_W-1:0]  score;
		logic              cls;
	} prediction_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TB_IN_W-1:0]  s_tdata;   // sample_label, feature_0 .. feature_7
	logic [ACT_W-1:0]    s_tuser;   // action
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // predicted_class, decision_score, margin_violated
	logic                cfg_we;
	logic                cfg_index;
	logic [RATE_W-1:0]   cfg_data;

	// trainer state as the bench sees it
	logic signed [WGT_W-1:0] model_w [NF];
	logic signed [WGT_W-1:0] model_b;
	logic [RATE_W-1:0]       model_lr;
	logic [RATE_W-1:0]       model_lam;

	prediction_t pending_predictions [$];
	prediction_t want;
	int          mismatch_count;
	int          cycle_count;
	int          source_idle_pct;
	int          sink_idle_pct;
	bit          stall_request;
	int          stall_len;

	linear_svm_sgd_trainer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_s32(longint v);
		if (v > S32_HI)
			return S32_HI;
		if (v < S32_LO)
			return S32_LO;
		return v;
	endfunction

	// Score the sample against the current weights, then apply the SGD step
	function automatic prediction_t score_and_update(sample_t s);
		prediction_t r;
		longint acc, sc, lr, lrlam, w, nw, st;
		longint x [NF];
		bit pos, viol;
		pos = s.label;
		r = '0;
		if (s.act == ACT_CLEAR) begin
			foreach (model_w[i])
				model_w[i] = '0;
			model_b = '0;
			return r;
		end
		acc = 0;
		for (int i = 0; i < NF; i++) begin
			x[i] = longint'($signed(s.feat[i]));
			acc += x[i] * longint'(model_w[i]);
		end
		sc = clamp_s32((acc >>> 12) + longint'(model_b));
		viol = pos ? (sc < Q24_ONE) : (-sc < Q24_ONE);
		r.cls = (sc >= 0);
		r.score = sc[WGT_W-1:0];
		r.viol = viol;
		if (s.act == ACT_TRAIN) begin
			lr = longint'(model_lr);
			lrlam = lr * longint'(model_lam);
			for (int i = 0; i < NF; i++) begin
				w = longint'(model_w[i]);
				nw = w - ((lrlam * w + HALF_32) >>> 32);
				if (viol) begin
					st = (lr * x[i] + 8) >>> 4;
					nw += pos ? st : -st;
				end
				model_w[i] = clamp_s32(nw);
			end
			if (viol)
				model_b = clamp_s32(pos ? longint'(model_b) + lr * 256
						: longint'(model_b) - lr * 256);
		end
		return r;
	endfunction

	// even features take one value, odd features the other
	function automatic sample_t make_sample(logic [ACT_W-1:0] act, logic label,
			logic [FEAT_W-1:0] v_even, logic [FEAT_W-1:0] v_odd);
		sample_t s;
		s.act = act;
		s.label = label;
		for (int i = 0; i < NF; i++)
			s.feat[i] = (i % 2 == 0) ? v_even : v_odd;
		return s;
	endfunction

	function automatic logic [FEAT_W-1:0] draw_feature();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65)
			return FEAT_W'(int'($urandom_range(16383)) - 8192);  // within +-2.0
		if (pick < 85)
			return FEAT_W'($urandom);
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h0001;
			default: return 16'hFFFF;
		endcase
	endfunction

	// labels mostly follow a fixed hyperplane so training has something to learn
	function automatic sample_t draw_sample();
		sample_t s;
		int pick;
		int side;
		pick = $urandom_range(99);
		if (pick < 2)
			s.act = ACT_CLEAR;
		else if (pick < 64)
			s.act = ACT_TRAIN;
		else if (pick < 92)
			s.act = ACT_PREDICT;
		else
			s.act = ACT_UNUSED;
		for (int i = 0; i < NF; i++)
			s.feat[i] = draw_feature();
		side = int'($signed(s.feat[0])) - int'($signed(s.feat[3]))
				+ int'($signed(s.feat[5]));
		s.label = (side >= 0);
		if ($urandom_range(99) < 12)
			s.label = !s.label;
		return s;
	endfunction

	function automatic logic [RATE_W-1:0] draw_rate();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 16'd1;
			3, 4: return RATE_W'($urandom);
			default: return RATE_W'($urandom_range(8000, 1));
		endcase
	endfunction

	// Offer one item, hold it until taken, then record its prediction
	task automatic send_item(sample_t s);
		logic [TB_IN_W-1:0] d;
		d = '0;
		d[0] = s.label;
		for (int i = 0; i < NF; i++)
			d[1 + FEAT_W * i +: FEAT_W] = s.feat[i];
		@(negedge clk);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= d;
		s_tuser <= s.act;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pending_predictions.insert(pending_predictions.size(), score_and_update(s));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_predictions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [RATE_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LEARN_RATE)
			model_lr = val;
		else
			model_lam = val;
	endtask

	// rates change only with nothing in flight
	task automatic apply_rates(logic [RATE_W-1:0] lr, logic [RATE_W-1:0] lam);
		wait_drained();
		write_reg(CFG_LEARN_RATE, lr);
		write_reg(CFG_REG_STRENGTH, lam);
	endtask

	// Zero weights and reset rates: margin flag set for both labels
	task automatic test_after_reset();
		send_item(make_sample(ACT_PREDICT, 1'b0, 16'h0000, 16'h0000));
		send_item(make_sample(ACT_PREDICT, 1'b1, 16'h7FFF, 16'h8000));
		send_item(make_sample(ACT_UNUSED, 1'b1, 16'h7FFF, 16'h7FFF));
		send_item(make_sample(ACT_TRAIN, 1'b1, 16'h1234, 16'hEDCB));
		send_item(make_sample(ACT_PREDICT, 1'b1, 16'h1234, 16'hEDCB));
	endtask

	// Full learn rate drives the score into both rails, then clear
	task automatic test_saturation_and_clear();
		apply_rates('1, '0);
		send_item(make_sample(ACT_TRAIN, 1'b1, 16'h7FFF, 16'h7FFF));
		send_item(make_sample(ACT_PREDICT, 1'b1, 16'h7FFF, 16'h7FFF));
		send_item(make_sample(ACT_PREDICT, 1'b0, 16'h8000, 16'h8000));
		send_item(make_sample(ACT_PREDICT, 1'b1, 16'h8000, 16'h8000));
		send_item(make_sample(ACT_TRAIN, 1'b0, 16'h8000, 16'h8000));
		send_item(make_sample(ACT_UNUSED, 1'b0, 16'h8000, 16'h7FFF));
		send_item(make_sample(ACT_CLEAR, 1'b1, 16'h7FFF, 16'h7FFF));
		send_item(make_sample(ACT_PREDICT, 1'b1, 16'h7FFF, 16'h7FFF));
	endtask

	// Heavy decay, then the smallest nonzero rates, then a frozen learner
	task automatic test_decay_only();
		apply_rates('1, '1);
		send_item(make_sample(ACT_TRAIN, 1'b1, 16'h1000, 16'h1000));
		send_item(make_sample(ACT_TRAIN, 1'b1, 16'h1000, 16'h1000));
		send_item(make_sample(ACT_TRAIN, 1'b0, 16'h7FFF, 16'h8000));
		apply_rates(16'd1, 16'd1);
		send_item(make_sample(ACT_TRAIN, 1'b0, 16'hFFFF, 16'h0001));
		apply_rates('0, 16'd655);
		send_item(make_sample(ACT_TRAIN, 1'b1, 16'h5555, 16'hAAAA));
		send_item(make_sample(ACT_PREDICT, 1'b0, 16'h5555, 16'hAAAA));
	endtask

	task automatic test_random_traffic(int src_pct, int sink_pct, int n_items);
		source_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		for (int chunk = 0; chunk < 3; chunk++) begin
			apply_rates(draw_rate(), draw_rate());
			repeat (n_items / 3)
				send_item(draw_sample());
		end
	endtask

	// Sink stops for a long stretch while the source keeps offering
	task automatic test_output_stall();
		apply_rates(16'd655, 16'd655);
		stall_len = 300;
		stall_request = 1'b1;
		repeat (12)
			send_item(draw_sample());
		wait_drained();
	endtask

	// sink side
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_tready <= 1'b0;
				stall_request = 1'b0;
				repeat (stall_len)
					@(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_predictions.size() == 0) begin
				$display("%0t: result item with none expected, expected none, actual %h",
						$time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_predictions.pop_front();
				if (m_tdata[0] !== want.cls) begin
					$display("%0t: predicted_class expected %0d, actual %0d",
							$time, want.cls, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[WGT_W:1] !== want.score) begin
					$display("%0t: decision_score expected %0d, actual %0d",
							$time, $signed(want.score), $signed(m_tdata[WGT_W:1]));
					mismatch_count++;
				end
				if (m_tdata[WGT_W+1] !== want.viol) begin
					$display("%0t: margin_violated expected %0d, actual %0d",
							$time, want.viol, m_tdata[WGT_W+1]);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("[linear_svm_sgd_trainer_top] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_PREDICT;
		cfg_we = 1'b0;
		cfg_index = CFG_LEARN_RATE;
		cfg_data = '0;
		mismatch_count = 0;
		cycle_count = 0;
		source_idle_pct = 0;
		sink_idle_pct = 0;
		stall_request = 1'b0;
		stall_len = 0;
		foreach (model_w[i])
			model_w[i] = '0;
		model_b = '0;
		model_lr = RATE_RESET;
		model_lam = RATE_RESET;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_saturation_and_clear();
		test_decay_only();
		test_random_traffic(21, 63, 330);
		test_output_stall();
		test_random_traffic(63, 21, 330);
		test_random_traffic(0, 0, 330);

		wait_drained();
		repeat (2 * PIPE_LAT)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("[linear_svm_sgd_trainer_top] OK");
		else
			$display("[linear_svm_sgd_trainer_top] ERROR");
		$finish;
	end

endmodule
